// ----- rtl/dpm_pkg.sv -----
// Package for the dense minimum spanning tree unit.
// Holds shared constants, mode codes and the sequencer state type; no dependencies.
package dpm_pkg;

   localparam int MAX_NODES_DEF   = 64;
   localparam int WEIGHT_BITS_DEF = 32;
   localparam int NODE_CNT_W      = 7;
   localparam int NODE_CNT_RST    = 64;
   localparam int TOTAL_W         = 38;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

// ----- rtl/dpm_wmem.sv -----
// Weight store of the dense minimum spanning tree unit.
// One write port and one registered read port; uses no package.
module dpm_wmem #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dense_prim_mst_unit.sv -----
// Top level of the dense minimum spanning tree unit (Prim's method on a weight matrix).
// Depends on dpm_pkg and dpm_wmem.
//
//   port group   direction   handshake             payload
//   req_         in          req_valid/req_stall   mode, row, col, weight
//   rsp_         out         rsp_valid/rsp_stall   added_node, partner_node, total_length, last
//   csr_         in          csr_wr_en             node_count
//
// Load requests stream one per cycle while the sequencer is idle.
// A start request with n nodes runs n-1 passes over the outside list; each pass reads
// the slot memory, then the weight memory, then goes through the compare stage, and
// ends by emitting one result.
// The input is stalled for the whole run; a stalled result only delays the next pass.
// Reset is synchronous and clears the sequencer, the counters and the result valid.
module dense_prim_mst_unit #(
   parameter int MAX_NODES   = dpm_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = dpm_pkg::WEIGHT_BITS_DEF,
   localparam int IW = $clog2(MAX_NODES),
   localparam int TW = dpm_pkg::TOTAL_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [IW-1:0]                 req_row,
   input  logic [IW-1:0]                 req_col,
   input  logic [WEIGHT_BITS-1:0]        req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [IW-1:0]                 rsp_added_node,
   output logic [IW-1:0]                 rsp_partner_node,
   output logic [TW-1:0]                 rsp_total_length,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [dpm_pkg::NODE_CNT_W-1:0] csr_wr_data
);

   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int WB    = WEIGHT_BITS;
   localparam int SUM_W = ((TW > WB) ? TW : WB) + 1;

   dpm_pkg::state_type state_ff, state_in;

   logic [dpm_pkg::NODE_CNT_W-1:0] node_count_ff;
   logic [CW-1:0] cnt_ff, cnt_in, iss_ff, iss_in, n_eff;
   logic          first_ff, first_in;
   logic [IW-1:0] newest_ff, newest_in;
   logic [TW-1:0] sum_ff, sum_in;

   logic          p1_ff, p1_in, p2_ff, p2_in;
   logic [CW-1:0] idx1_ff, idx2_ff;
   logic [IW-1:0] node2_ff, clo2_ff;
   logic [WB-1:0] best2_ff;

   logic [WB-1:0] cheap_ff, cheap_in, lbest_ff, lbest_in;
   logic [IW-1:0] pick_ff, pick_in, pnode_ff, pnode_in, pclo_ff, pclo_in;
   logic [IW-1:0] lnode_ff, lnode_in, lclo_ff, lclo_in;

   logic [IW-1:0] list_mem_ff [MAX_NODES];
   logic [IW-1:0] clo_mem_ff [MAX_NODES];
   logic [WB-1:0] best_mem_ff [MAX_NODES];
   logic [IW-1:0] list_rd_ff, clo_rd_ff;
   logic [WB-1:0] best_rd_ff;

   logic          sw_en;
   logic [IW-1:0] sw_addr, sw_list, sw_clo;
   logic [WB-1:0] sw_best;

   logic          w_wr_en;
   logic [IW-1:0] node1;
   logic [WB-1:0] w_rd;
   logic [WB-1:0] nb;
   logic [IW-1:0] nc;
   logic [SUM_W-1:0] sum_wide;
   logic [TW-1:0]    sum_sat;

   logic          rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [IW-1:0] rsp_added_ff, rsp_partner_ff;
   logic [TW-1:0] rsp_total_ff;
   logic          rsp_last_ff;

   assign req_stall = (state_ff != dpm_pkg::ST_IDLE);
   assign w_wr_en   = req_valid && !req_stall && (req_mode == dpm_pkg::MODE_LOAD)
                      && (32'(req_row) < 32'(MAX_NODES)) && (32'(req_col) < 32'(MAX_NODES));
   assign n_eff     = (32'(node_count_ff) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                      : CW'(node_count_ff);
   assign node1     = first_ff ? idx1_ff[IW-1:0] : list_rd_ff;

   dpm_wmem #(
      .ADDR_W (2 * IW),
      .DATA_W (WB)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_weight),
      .rd_addr ({node1, newest_ff}),
      .rd_data (w_rd)
   );

   always_comb begin
      if (first_ff || (w_rd < best2_ff)) begin
         nb = w_rd;
         nc = newest_ff;
      end else begin
         nb = best2_ff;
         nc = clo2_ff;
      end
      sum_wide = SUM_W'(sum_ff) + SUM_W'(cheap_ff);
      sum_sat  = (sum_wide > SUM_W'({TW{1'b1}})) ? {TW{1'b1}} : sum_wide[TW-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      iss_in    = iss_ff;
      first_in  = first_ff;
      newest_in = newest_ff;
      sum_in    = sum_ff;
      p1_in     = 1'b0;
      p2_in     = p1_ff;
      cheap_in  = cheap_ff;
      pick_in   = pick_ff;
      pnode_in  = pnode_ff;
      pclo_in   = pclo_ff;
      lnode_in  = lnode_ff;
      lclo_in   = lclo_ff;
      lbest_in  = lbest_ff;
      sw_en     = 1'b0;
      sw_addr   = idx2_ff[IW-1:0];
      sw_list   = node2_ff;
      sw_clo    = nc;
      sw_best   = nb;
      rsp_load  = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         dpm_pkg::ST_IDLE: begin
            if (req_valid && (req_mode == dpm_pkg::MODE_START) && (n_eff >= CW'(2))) begin
               cnt_in    = n_eff - CW'(1);
               newest_in = IW'(n_eff - CW'(1));
               sum_in    = '0;
               iss_in    = '0;
               first_in  = 1'b1;
               state_in  = dpm_pkg::ST_SCAN;
            end
         end
         dpm_pkg::ST_SCAN: begin
            if (iss_ff < cnt_ff) begin
               p1_in  = 1'b1;
               iss_in = iss_ff + CW'(1);
            end
            if (p2_ff) begin
               sw_en = 1'b1;
               if ((idx2_ff == '0) || (nb <= cheap_ff)) begin
                  cheap_in = nb;
                  pick_in  = idx2_ff[IW-1:0];
                  pnode_in = node2_ff;
                  pclo_in  = nc;
               end
               if (idx2_ff == cnt_ff - CW'(1)) begin
                  lnode_in = node2_ff;
                  lclo_in  = nc;
                  lbest_in = nb;
                  state_in = dpm_pkg::ST_RESULT;
               end
            end
         end
         dpm_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               sw_en        = 1'b1;
               sw_addr      = pick_ff;
               sw_list      = lnode_ff;
               sw_clo       = lclo_ff;
               sw_best      = lbest_ff;
               sum_in       = sum_sat;
               newest_in    = pnode_ff;
               cnt_in       = cnt_ff - CW'(1);
               iss_in       = '0;
               first_in     = 1'b0;
               state_in     = (cnt_ff == CW'(1)) ? dpm_pkg::ST_IDLE : dpm_pkg::ST_SCAN;
            end
         end
         default: state_in = dpm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dpm_pkg::ST_IDLE;
         node_count_ff <= dpm_pkg::NODE_CNT_W'(dpm_pkg::NODE_CNT_RST);
         cnt_ff        <= '0;
         iss_ff        <= '0;
         first_ff      <= 1'b0;
         newest_ff     <= '0;
         sum_ff        <= '0;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         first_ff     <= first_in;
         newest_ff    <= newest_in;
         sum_ff       <= sum_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= iss_ff;
      idx2_ff  <= idx1_ff;
      node2_ff <= node1;
      clo2_ff  <= clo_rd_ff;
      best2_ff <= best_rd_ff;
      cheap_ff <= cheap_in;
      pick_ff  <= pick_in;
      pnode_ff <= pnode_in;
      pclo_ff  <= pclo_in;
      lnode_ff <= lnode_in;
      lclo_ff  <= lclo_in;
      lbest_ff <= lbest_in;
      list_rd_ff <= list_mem_ff[iss_ff[IW-1:0]];
      clo_rd_ff  <= clo_mem_ff[iss_ff[IW-1:0]];
      best_rd_ff <= best_mem_ff[iss_ff[IW-1:0]];
      if (sw_en) begin
         list_mem_ff[sw_addr] <= sw_list;
         clo_mem_ff[sw_addr]  <= sw_clo;
         best_mem_ff[sw_addr] <= sw_best;
      end
      if (rsp_load) begin
         rsp_added_ff   <= pnode_ff;
         rsp_partner_ff <= pclo_ff;
         rsp_total_ff   <= sum_sat;
         rsp_last_ff    <= (cnt_ff == CW'(1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_added_node   = rsp_added_ff;
   assign rsp_partner_node = rsp_partner_ff;
   assign rsp_total_length = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- rtl/dpm_checker.sv -----
// Port-level checks for the dense minimum spanning tree unit, with its bind.
// Depends on dense_prim_mst_unit and dpm_pkg.
module dpm_checker #(
   parameter int IW = 6,
   parameter int TW = dpm_pkg::TOTAL_W
) (
   input logic          clock,
   input logic          reset,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [IW-1:0] rsp_added_node,
   input logic [IW-1:0] rsp_partner_node,
   input logic [TW-1:0] rsp_total_length,
   input logic          rsp_last
);

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("Reset did not clear the result valid or the request stall.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_added_node)
         && $stable(rsp_total_length) && $stable(rsp_last))
      else $error("A stalled result changed.");

   a_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_added_node != rsp_partner_node)
      else $error("A result joins a node to itself.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("The block took requests before the tree was complete.");

endmodule

bind dense_prim_mst_unit dpm_checker #(
   .IW ($clog2(MAX_NODES)),
   .TW (dpm_pkg::TOTAL_W)
) u_dpm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_added_node   (rsp_added_node),
   .rsp_partner_node (rsp_partner_node),
   .rsp_total_length (rsp_total_length),
   .rsp_last         (rsp_last)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for dense_prim_mst_unit: a directed table, then random graphs.
// Expected edges come from the table, or from a predictor of Prim's method in this file.
// Depends on dpm_pkg and the RTL of the unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]  added;
      logic [5:0]  partner;
      logic [37:0] total;
      logic        last;
   } mst_edge_type;

   typedef enum logic {OP_CFG, OP_REQ} op_kind_type;

   typedef struct {
      op_kind_type  kind;
      logic         mode;
      logic [5:0]   row;
      logic [5:0]   col;
      logic [31:0]  weight;
      int           n_exp;
      mst_edge_type e0;
      mst_edge_type e1;
   } dir_row_type;

   localparam logic [37:0] SUM_MAX = {38{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = dpm_pkg::MODE_LOAD;
   logic [5:0]  req_row = '0;
   logic [5:0]  req_col = '0;
   logic [31:0] req_weight = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_added_node;
   logic [5:0]  rsp_partner_node;
   logic [37:0] rsp_total_length;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [dpm_pkg::NODE_CNT_W-1:0] csr_wr_data = '0;

   logic [31:0] weight_mat [64][64];
   bit          written [64][64];
   logic [dpm_pkg::NODE_CNT_W-1:0] node_cnt_reg;
   mst_edge_type edge_q [$];

   int err_count = 0;
   int req_count = 0;
   int start_count = 0;
   int edge_count = 0;
   int burst_left = 0;
   int hold_left = 0;
   bit hold_req = 0;
   int cyc = 0;

   dense_prim_mst_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_row(req_row), .req_col(req_col), .req_weight(req_weight),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_added_node(rsp_added_node), .rsp_partner_node(rsp_partner_node),
      .rsp_total_length(rsp_total_length), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("dense_prim_mst_unit verification failed");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   function automatic void predict_tree();
      int n, k, pick, newest;
      logic [5:0]  members [64];
      logic [5:0]  closest [64];
      logic [31:0] best [64];
      logic [31:0] cheapest;
      logic [38:0] sum;
      mst_edge_type e;
      n = (int'(node_cnt_reg) > 64) ? 64 : int'(node_cnt_reg);
      if (n < 2) return;
      newest = n - 1;
      k = n - 1;
      sum = '0;
      for (int i = 0; i < k; i++) begin
         members[i] = 6'(i);
         closest[i] = 6'(newest);
         best[i] = weight_mat[i][newest];
      end
      while (k > 0) begin
         for (int i = 0; i < k; i++) begin
            if (best[i] > weight_mat[members[i]][newest]) begin
               closest[i] = 6'(newest);
               best[i] = weight_mat[members[i]][newest];
            end
         end
         cheapest = best[0];
         pick = 0;
         for (int i = 0; i < k; i++) begin
            if (best[i] <= cheapest) begin
               cheapest = best[i];
               pick = i;
            end
         end
         newest = int'(members[pick]);
         sum = sum + 39'(cheapest);
         if (sum > 39'(SUM_MAX)) sum = 39'(SUM_MAX);
         e.added = members[pick];
         e.partner = closest[pick];
         e.total = sum[37:0];
         e.last = (k == 1);
         edge_q.push_back(e);
         best[pick] = best[k-1];
         members[pick] = members[k-1];
         closest[pick] = closest[k-1];
         k--;
      end
   endfunction

   task automatic send_request(logic mode, logic [5:0] row, logic [5:0] col,
                               logic [31:0] w, bit predict);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_row <= row;
      req_col <= col;
      req_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
      if (mode == dpm_pkg::MODE_LOAD) begin
         weight_mat[row][col] = w;
         written[row][col] = 1;
      end else begin
         start_count++;
         if (predict) predict_tree();
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (edge_q.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_node_count(logic [dpm_pkg::NODE_CNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_cnt_reg = value;
   endtask

   task automatic fill_graph(int n, bit tie_prone);
      logic [31:0] w;
      for (int r = 0; r < n - 1; r++) begin
         for (int c = 0; c < n; c++) begin
            if (r != c && !written[r][c]) begin
               w = tie_prone ? $urandom_range(0, 3) : $urandom;
               send_request(dpm_pkg::MODE_LOAD, 6'(r), 6'(c), w, 1);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      cyc++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req = 0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         case ((cyc / 97) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      mst_edge_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         edge_count++;
         if (edge_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_added_node, 0);
         end else begin
            want = edge_q.pop_front();
            if (rsp_added_node !== want.added)
               report_mismatch("added_node", rsp_added_node, want.added);
            if (rsp_partner_node !== want.partner)
               report_mismatch("partner_node", rsp_partner_node, want.partner);
            if (rsp_total_length !== want.total)
               report_mismatch("total_length", rsp_total_length, want.total);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   dir_row_type dir_tab [20] = '{
      '{OP_CFG, 0, 0, 0, 3, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 0, 2, 5, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 1, 2, 5, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 0, 1, 0, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 1, 0, 32'hFFFF_FFFF, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 2, 0, 7, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 2, 1, 9, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_START, 0, 0, 0, 2, '{6'd1, 6'd2, 38'd5, 1'b0},
                                                  '{6'd0, 6'd1, 38'd5, 1'b1}},
      '{OP_CFG, 0, 0, 0, 2, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 0, 1, 32'hFFFF_FFFF, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 1, 0, 0, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_START, 0, 0, 0, 1, '{6'd0, 6'd1, 38'hFFFF_FFFF, 1'b1}, '0},
      '{OP_CFG, 0, 0, 0, 1, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_START, 63, 63, 32'hFFFF_FFFF, 0, '0, '0},
      '{OP_CFG, 0, 0, 0, 0, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_START, 0, 0, 0, 0, '0, '0},
      '{OP_CFG, 0, 0, 0, 127, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 63, 63, 32'hFFFF_FFFF, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 63, 0, 0, 0, '0, '0},
      '{OP_REQ, dpm_pkg::MODE_LOAD, 0, 63, 32'hFFFF_FFFF, 0, '0, '0}
   };

   initial begin
      int phase;
      int n_eff;
      int cnt;
      logic [5:0] r, c;
      node_cnt_reg = dpm_pkg::NODE_CNT_W'(dpm_pkg::NODE_CNT_RST);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == OP_CFG) begin
            wait_idle();
            write_node_count(dir_tab[i].weight[dpm_pkg::NODE_CNT_W-1:0]);
         end else begin
            if (dir_tab[i].n_exp > 0) edge_q.push_back(dir_tab[i].e0);
            if (dir_tab[i].n_exp > 1) edge_q.push_back(dir_tab[i].e1);
            send_request(dir_tab[i].mode, dir_tab[i].row, dir_tab[i].col,
                         dir_tab[i].weight, 0);
         end
      end

      phase = 0;
      while (phase < 8 || req_count < 310) begin
         wait_idle();
         if (phase == 5 || $urandom_range(0, 9) != 0) cnt = $urandom_range(2, 10);
         else cnt = $urandom_range(0, 1);
         write_node_count(dpm_pkg::NODE_CNT_W'(cnt));
         n_eff = cnt;
         repeat ($urandom_range(0, 12)) begin
            if (n_eff >= 2 && $urandom_range(0, 9) < 7) begin
               r = 6'($urandom_range(0, n_eff - 1));
               c = 6'($urandom_range(0, n_eff - 1));
            end else begin
               r = 6'($urandom);
               c = 6'($urandom);
            end
            send_request(dpm_pkg::MODE_LOAD, r, c,
                         ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom), 1);
         end
         fill_graph(n_eff, phase[0]);
         if (phase == 5) hold_req = 1;
         send_request(dpm_pkg::MODE_START, 6'($urandom), 6'($urandom), $urandom, 1);
         if (phase == 5) begin
            repeat (8) begin
               send_request(dpm_pkg::MODE_LOAD, 6'($urandom_range(0, n_eff - 1)),
                            6'($urandom_range(0, n_eff - 1)), $urandom, 1);
            end
         end
         phase++;
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("Covered %0d requests, %0d starts and %0d tree edges over %0d graphs.",
               req_count, start_count, edge_count, phase);
      if (err_count == 0 && edge_q.size() == 0) begin
         $display("dense_prim_mst_unit verification clean");
      end else begin
         $display("dense_prim_mst_unit verification failed");
      end
      $finish;
   end

endmodule
